>>> design/vnfp_pkg.sv
`timescale 1ns / 1ps

package vnfp_pkg;

	// Cell coordinates: -1 .. 64 fits a signed byte for every legal grid size.
	typedef logic signed [7:0] cell_t;

	// Word handed from cell to cell: the pixel, its home cell and the best so far.
	typedef struct packed {
		logic [15:0] fx;
		logic [15:0] fy;
		cell_t       cx;
		cell_t       cy;
		logic [31:0] best;
		cell_t       ox;
		cell_t       oy;
	} chain_t;

	// One result word, last field in the lowest bits.
	typedef struct packed {
		logic [8:0]  hue;
		logic [15:0] glow;
		logic [31:0] dsq;
		logic [4:0]  oy;
		logic [4:0]  ox;
	} res_t;

	localparam logic [31:0] HASH_KX = 32'd374761393;
	localparam logic [31:0] HASH_KY = 32'd668265263;
	localparam logic [31:0] HASH_KS = 32'd2246822519;
	localparam logic [31:0] HASH_KM = 32'd1274126177;

	localparam logic [31:0] SALT_X   = 32'd1;
	localparam logic [31:0] SALT_Y   = 32'd2;
	localparam logic [31:0] SALT_HUE = 32'd3;

	localparam int          HUE_MOD   = 360;
	localparam logic [31:0] HUE_RECIP = 32'(64'h1_0000_0000 / HUE_MOD);

	// First hash round: linear mix of the cell coordinates and the salt.
	function automatic logic [31:0] hash_seed(cell_t x, cell_t y, logic [31:0] salt);
		logic [31:0] xw;
		logic [31:0] yw;
		xw = 32'(x);
		yw = 32'(y);
		return xw * HASH_KX + yw * HASH_KY + salt * HASH_KS;
	endfunction

endpackage

>>> design/vnfp_cell.sv
`timescale 1ns / 1ps

module vnfp_cell #(
	parameter int GRID_CELLS = 8,
	parameter int CELL_IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vnfp_pkg::chain_t in_word,
	input  logic [15:0]      phase,
	output logic             out_valid,
	output vnfp_pkg::chain_t out_word
);

	localparam int CS      = 65536 / GRID_CELLS;
	localparam int AMP     = CS / 4;
	localparam int WOB_MUL = 4 * AMP;
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / CS);
	localparam int DX = CELL_IDX % 3 - 1;
	localparam int DY = CELL_IDX / 3 - 1;
	localparam bit FIRST = (CELL_IDX == 0);
	localparam logic [16:0]        CS17  = 17'(CS);
	localparam logic signed [19:0] CS20  = 20'(CS);
	localparam logic signed [17:0] AMP18 = 18'(AMP);

	logic [6:0] v_q;

	vnfp_pkg::chain_t w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7;
	vnfp_pkg::cell_t  n_s1 [2];
	vnfp_pkg::cell_t  n_s2 [2];
	vnfp_pkg::cell_t  n_s3 [2];
	vnfp_pkg::cell_t  n_s4 [2];
	logic [31:0]        h0_s1 [2];
	logic [31:0]        m_s2  [2];
	logic [16:0]        h_s3  [2];
	logic [16:0]        q_s3  [2];
	logic [16:0]        wq_s3 [2];
	logic [16:0]        r_s4  [2];
	logic signed [17:0] wob_s4 [2];
	logic signed [19:0] e_s5  [2];
	logic [31:0]        d2_s6;

	vnfp_pkg::cell_t    n_c   [2];
	logic [31:0]        seed_c [2];
	logic [31:0]        mix_c [2];
	logic [31:0]        h_c   [2];
	logic [63:0]        qp_c  [2];
	logic [15:0]        p_c   [2];
	logic [16:0]        tri_c [2];
	logic [33:0]        wp_c  [2];
	logic [16:0]        r0_c  [2];
	logic [16:0]        r_c   [2];
	logic signed [19:0] px_c  [2];
	logic signed [19:0] f_c   [2];
	logic signed [39:0] sq_c  [2];
	logic               take_c;
	vnfp_pkg::chain_t   nx_c;

	always_comb begin
		n_c[0] = in_word.cx + vnfp_pkg::cell_t'(DX);
		n_c[1] = in_word.cy + vnfp_pkg::cell_t'(DY);
		for (int a = 0; a < 2; a++) begin
			seed_c[a] = vnfp_pkg::hash_seed(n_c[0], n_c[1],
				(a == 0) ? vnfp_pkg::SALT_X : vnfp_pkg::SALT_Y);
			mix_c[a]  = h0_s1[a] ^ (h0_s1[a] >> 13);
			h_c[a]    = m_s2[a] ^ (m_s2[a] >> 16);
			qp_c[a]   = 64'(h_c[a]) * 64'(RECIP);
			p_c[a]    = phase + h_c[a][15:0];
			tri_c[a]  = p_c[a][15] ? (17'd65536 - 17'(p_c[a])) : 17'(p_c[a]);
			wp_c[a]   = 34'(tri_c[a]) * 34'(WOB_MUL);
			r0_c[a]   = h_s3[a] - 17'(q_s3[a] * CS17);
			r_c[a]    = (r_s4[a] >= CS17) ? (r_s4[a] - CS17) : r_s4[a];
			px_c[a]   = 20'(n_s4[a]) * CS20 + $signed({3'b000, r_c[a]}) + 20'(wob_s4[a]);
			f_c[a]    = $signed({4'b0000, ((a == 0) ? w_s4.fx : w_s4.fy)});
			sq_c[a]   = e_s5[a] * e_s5[a];
		end
		take_c = FIRST || (d2_s6 < w_s6.best);
		nx_c = w_s6;
		if (take_c) begin
			nx_c.best = d2_s6;
			nx_c.ox   = w_s6.cx + vnfp_pkg::cell_t'(DX);
			nx_c.oy   = w_s6.cy + vnfp_pkg::cell_t'(DY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= in_word;
			w_s2 <= w_s1;
			w_s3 <= w_s2;
			w_s4 <= w_s3;
			w_s5 <= w_s4;
			w_s6 <= w_s5;
			for (int a = 0; a < 2; a++) begin
				n_s1[a]   <= n_c[a];
				n_s2[a]   <= n_s1[a];
				n_s3[a]   <= n_s2[a];
				n_s4[a]   <= n_s3[a];
				h0_s1[a]  <= seed_c[a];
				m_s2[a]   <= mix_c[a] * vnfp_pkg::HASH_KM;
				h_s3[a]   <= h_c[a][16:0];
				q_s3[a]   <= qp_c[a][48:32];
				wq_s3[a]  <= wp_c[a][32:16];
				r_s4[a]   <= r0_c[a];
				wob_s4[a] <= $signed({1'b0, wq_s3[a]}) - AMP18;
				e_s5[a]   <= f_c[a] - px_c[a];
			end
			d2_s6 <= sq_c[0][31:0] + sq_c[1][31:0];
			w_s7  <= nx_c;
		end
	end

	assign out_valid = v_q[6];
	assign out_word  = w_s7;

endmodule

>>> design/vnfp_finish.sv
`timescale 1ns / 1ps

module vnfp_finish #(
	parameter int GRID_CELLS       = 8,
	parameter int GLOW_TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vnfp_pkg::chain_t in_word,
	output logic             out_valid,
	output vnfp_pkg::res_t   out_res
);

	localparam int CS     = 65536 / GRID_CELLS;
	localparam int REACH  = (CS * 3) / 2;
	localparam logic [31:0] RECIP_R = 32'(64'h1_0000_0000 / REACH);
	localparam logic [31:0] REACH32 = 32'(REACH);
	localparam logic [15:0] GI_MAX  = 16'(GLOW_TABLE_DEPTH - 1);
	localparam int ROOT_N = 16;
	localparam int HUE_AT = 4;
	localparam logic [9:0] HUE_M10 = 10'(vnfp_pkg::HUE_MOD);

	typedef struct packed {
		vnfp_pkg::cell_t ox;
		vnfp_pkg::cell_t oy;
		logic [31:0]     dsq;
		logic [8:0]      hue;
	} side_t;

	logic [ROOT_N+2:0] v_q;
	logic [31:0] rv_q [ROOT_N+1];
	logic [31:0] rs_q [ROOT_N+1];
	side_t       sd_q [ROOT_N+1];
	logic [31:0] hu_s1, hu_s2;
	logic [9:0]  hh_s3, hq_s3, hr_s4;
	logic [31:0] qd_s1, xd_s1;
	side_t       sd_s1;

	logic [15:0] gi_c;
	logic [31:0] rv_c [ROOT_N];
	logic [31:0] rs_c [ROOT_N];
	logic [31:0] bit_c, sum_c;
	logic [31:0] hm_c, hh_c;
	logic [63:0] hp_c, qp_c;
	logic [8:0]  hue_c;
	logic [31:0] xd_c, rem_c, ramp_c;
	logic [15:0] glow_c;

	always_comb begin
		gi_c = (in_word.best[31:16] > GI_MAX) ? GI_MAX : in_word.best[31:16];
		for (int j = 0; j < ROOT_N; j++) begin
			bit_c = 32'd1 << (30 - 2 * j);
			sum_c = rs_q[j] + bit_c;
			if (rv_q[j] >= sum_c) begin
				rv_c[j] = rv_q[j] - sum_c;
				rs_c[j] = (rs_q[j] >> 1) + bit_c;
			end else begin
				rv_c[j] = rv_q[j];
				rs_c[j] = rs_q[j] >> 1;
			end
		end
		hm_c  = hu_s1 ^ (hu_s1 >> 13);
		hh_c  = hu_s2 ^ (hu_s2 >> 16);
		hp_c  = 64'(hh_c) * 64'(vnfp_pkg::HUE_RECIP);
		hue_c = 9'((hr_s4 >= HUE_M10) ? (hr_s4 - HUE_M10) : hr_s4);
		xd_c  = {rs_q[ROOT_N][15:0], 16'h0000};
		qp_c  = 64'(xd_c) * 64'(RECIP_R);
		rem_c = xd_s1 - qd_s1 * REACH32;
		ramp_c = (rem_c >= REACH32) ? (qd_s1 + 32'd1) : qd_s1;
		if (ramp_c == 32'd0) begin
			glow_c = 16'hFFFF;
		end else if (ramp_c >= 32'd32768) begin
			glow_c = 16'd32768;
		end else begin
			glow_c = 16'(17'd65536 - 17'(ramp_c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[ROOT_N+1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv_q[0] <= {gi_c, 16'h0000};
			rs_q[0] <= '0;
			sd_q[0] <= '{ox: in_word.ox, oy: in_word.oy, dsq: in_word.best, hue: '0};
			hu_s1   <= vnfp_pkg::hash_seed(in_word.ox, in_word.oy, vnfp_pkg::SALT_HUE);
			hu_s2   <= hm_c * vnfp_pkg::HASH_KM;
			hh_s3   <= hh_c[9:0];
			hq_s3   <= hp_c[41:32];
			hr_s4   <= hh_s3 - 10'(hq_s3 * HUE_M10);
			for (int j = 0; j < ROOT_N; j++) begin
				rv_q[j+1] <= rv_c[j];
				rs_q[j+1] <= rs_c[j];
				if (j == HUE_AT - 1) begin
					sd_q[j+1] <= '{ox: sd_q[j].ox, oy: sd_q[j].oy, dsq: sd_q[j].dsq,
						hue: hue_c};
				end else begin
					sd_q[j+1] <= sd_q[j];
				end
			end
			qd_s1 <= qp_c[63:32];
			xd_s1 <= xd_c;
			sd_s1 <= sd_q[ROOT_N];
			out_res.ox   <= sd_s1.ox[4:0];
			out_res.oy   <= sd_s1.oy[4:0];
			out_res.dsq  <= sd_s1.dsq;
			out_res.hue  <= sd_s1.hue;
			out_res.glow <= glow_c;
		end
	end

	assign out_valid = v_q[ROOT_N+2];

endmodule

>>> design/voronoi_nearest_feature_pixel.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                  | Word
// ---------+-----+--------------------------+------------------------------------------
// pixel    | in  | s_tvalid/s_tready/s_tdata| pixel_x, pixel_y
// result   | out | m_tvalid/m_tready/m_tdata| owner_cell_x/y, nearest_dist_sq, glow, hue
// config   | in  | cfg_wr_en/cfg_wr_data    | anim_phase
//
// One pixel word is taken per clock while s_tready is high. The path holds
// 2 + 9*7 + 19 + 1 = 85 register stages and the accepting edge loads the first:
// two stages find the home cell, each of the nine candidate cells is a seven-stage
// slice, the finish runs 19 stages (16 of them the glow square root), then the output.
// arst_n clears all valid flags and sets anim_phase to zero; payload is not reset.
// A stall at m_tready is absorbed by a one-word skid register behind the output
// register; while the skid holds a word the whole chain freezes and s_tready drops.

module voronoi_nearest_feature_pixel #(
	parameter int GRID_CELLS       = 8,
	parameter int GLOW_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // anim_phase
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // [15:0] pixel_x, [31:16] pixel_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata        // [4:0] owner_cell_x, [9:5] owner_cell_y,
	                                   // [41:10] nearest_dist_sq, [57:42] glow_value,
	                                   // [66:58] owner_hue, [71:67] zero
);

	localparam int CS = 65536 / GRID_CELLS;
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / CS);
	localparam logic [31:0] CS32  = 32'(CS);
	localparam int N_CELLS = 9;

	logic [15:0] phase_q;
	logic        en;

	// home cell: reciprocal multiply, then one correction step
	logic [1:0]       fv_q;
	logic [15:0]      f_f1 [2];
	logic [7:0]       q_f1 [2];
	vnfp_pkg::chain_t w_f2;
	logic [63:0]      qp_c [2];
	logic [31:0]      rem_c [2];
	logic [7:0]       cell_c [2];

	logic             cv [N_CELLS+1];
	vnfp_pkg::chain_t cw [N_CELLS+1];

	logic           fin_valid;
	vnfp_pkg::res_t fin_res;

	vnfp_pkg::res_t o_q, sk_q;
	logic           o_valid_q, sk_valid_q;
	logic           take;

	// hold phase between frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cfg_wr_en) begin
			phase_q <= cfg_wr_data;
		end
	end

	assign en       = !sk_valid_q;
	assign s_tready = en;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			qp_c[a]   = 64'((a == 0) ? s_tdata[15:0] : s_tdata[31:16]) * 64'(RECIP);
			rem_c[a]  = 32'(f_f1[a]) - 32'(q_f1[a]) * CS32;
			cell_c[a] = (rem_c[a] >= CS32) ? (q_f1[a] + 8'd1) : q_f1[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (en) begin
			fv_q <= {fv_q[0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_f1[0] <= s_tdata[15:0];
			f_f1[1] <= s_tdata[31:16];
			q_f1[0] <= qp_c[0][39:32];
			q_f1[1] <= qp_c[1][39:32];
			w_f2 <= '{fx: f_f1[0], fy: f_f1[1], cx: cell_c[0], cy: cell_c[1],
				best: '0, ox: '0, oy: '0};
		end
	end

	assign cv[0] = fv_q[1];
	assign cw[0] = w_f2;

	// nine candidate cells in scan order: rows outer, columns inner
	for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
		vnfp_cell #(
			.GRID_CELLS(GRID_CELLS),
			.CELL_IDX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cv[k]),
			.in_word  (cw[k]),
			.phase    (phase_q),
			.out_valid(cv[k+1]),
			.out_word (cw[k+1])
		);
	end

	vnfp_finish #(
		.GRID_CELLS      (GRID_CELLS),
		.GLOW_TABLE_DEPTH(GLOW_TABLE_DEPTH)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cv[N_CELLS]),
		.in_word  (cw[N_CELLS]),
		.out_valid(fin_valid),
		.out_res  (fin_res)
	);

	// output register plus skid: drain skid first, else land the chain's word
	assign take = o_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (take) begin
				sk_valid_q <= 1'b0;
			end
		end else if (fin_valid) begin
			if (!o_valid_q || take) begin
				o_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (take) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (take) begin
				o_q <= sk_q;
			end
		end else if (fin_valid) begin
			if (!o_valid_q || take) begin
				o_q <= fin_res;
			end else begin
				sk_q <= fin_res;
			end
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'b00000, o_q};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> o_valid_q)
		else $error("skid full while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(o_valid_q && !m_tready))
		else $error("skid loaded without an output stall");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> (o_q.hue < 9'(vnfp_pkg::HUE_MOD)))
		else $error("hue out of range");

	a_glow_floor: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> o_q.glow[15])
		else $error("glow below half scale");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CELL_SPAN   = 8192;
	localparam int WOBBLE_AMP  = CELL_SPAN / 4;
	localparam int GLOW_REACH  = CELL_SPAN * 3 / 2;
	localparam int GLOW_DEPTH  = 1024;
	localparam int PIPE_DEPTH  = 85;
	localparam int SETTLE      = PIPE_DEPTH + 10;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // [15:0] pixel_x, [31:16] pixel_y
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;          // [4:0] cell x, [9:5] cell y, [41:10] dist,
	                               // [57:42] glow, [66:58] hue

	// Predictor state: animation phase and the glow curve
	logic [15:0] phase_model = '0;
	logic [15:0] glow_curve [GLOW_DEPTH];

	logic [31:0]    pixel_q [$];   // words waiting for the driver
	vnfp_pkg::res_t owner_q [$];   // expected results, oldest first

	int  fail_cnt = 0;
	bit  calm = 1'b0;              // no idling in the last phase
	bit  hold_req = 1'b0;          // ask the receiver for one long hold-off
	int  quiet_cycles = 0;

	voronoi_nearest_feature_pixel i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always #5 clk = ~clk;

	// Cell hash: linear mix, then xor-shift and multiply, all mod 2^32
	function automatic logic [31:0] scramble_cell(int cx, int cy, logic [31:0] salt);
		logic [31:0] h;
		logic [31:0] xw;
		logic [31:0] yw;
		xw = cx;
		yw = cy;
		h = xw * vnfp_pkg::HASH_KX + yw * vnfp_pkg::HASH_KY + salt * vnfp_pkg::HASH_KS;
		h = (h ^ (h >> 13)) * vnfp_pkg::HASH_KM;
		return h ^ (h >> 16);
	endfunction

	// Triangle wave over one Q0.16 period, amplitude WOBBLE_AMP
	function automatic longint wobble_offset(logic [31:0] ph);
		longint p;
		longint tri_w;
		p = longint'(ph[15:0]);
		tri_w = (p < 32768) ? p : 65536 - p;
		return (tri_w * 4 * WOBBLE_AMP) / 65536 - WOBBLE_AMP;
	endfunction

	function automatic longint feature_coord(int c, logic [31:0] h);
		return longint'(c) * CELL_SPAN + longint'(h % CELL_SPAN)
		       + wobble_offset({16'h0, phase_model} + h);
	endfunction

	// Scan the 3x3 neighborhood; strict less-than keeps the first on a tie
	function automatic vnfp_pkg::res_t nearest_owner(logic [15:0] fx, logic [15:0] fy);
		vnfp_pkg::res_t r;
		int          cx;
		int          cy;
		int          nx;
		int          ny;
		int          ox;
		int          oy;
		logic [31:0] best;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [31:0] d2;
		logic [31:0] gi;
		bit          have;
		cx = fx / CELL_SPAN;
		cy = fy / CELL_SPAN;
		have = 0;
		best = '0;
		ox = 0;
		oy = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				nx = cx + dx;
				ny = cy + dy;
				ex = 32'(longint'(fx) -
					feature_coord(nx, scramble_cell(nx, ny, vnfp_pkg::SALT_X)));
				ey = 32'(longint'(fy) -
					feature_coord(ny, scramble_cell(nx, ny, vnfp_pkg::SALT_Y)));
				d2 = ex * ex + ey * ey;
				if (!have || d2 < best) begin
					have = 1;
					best = d2;
					ox = nx;
					oy = ny;
				end
			end
		end
		gi = best >> 16;
		if (gi >= GLOW_DEPTH)
			gi = GLOW_DEPTH - 1;
		r.ox = ox[4:0];
		r.oy = oy[4:0];
		r.dsq = best;
		r.glow = glow_curve[gi[9:0]];
		r.hue = 9'(scramble_cell(ox, oy, vnfp_pkg::SALT_HUE) % vnfp_pkg::HUE_MOD);
		return r;
	endfunction

	// Driver: offer queued words, idle in random bursts
	int send_gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			owner_q.push_back(nearest_owner(s_tdata[15:0], s_tdata[31:16]));
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 6);
				s_tvalid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				s_tdata <= pixel_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: stall in random bursts, once for a long stretch; check each word
	int  recv_gap = 0;
	bit  hold_taken = 1'b0;
	always @(posedge clk) begin
		vnfp_pkg::res_t got;
		vnfp_pkg::res_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[66:0];
			if (owner_q.size() == 0) begin
				$display("%0t: result word with none expected, got %h", $time, got);
				fail_cnt++;
			end else begin
				want = owner_q.pop_front();
				if (got.ox !== want.ox || got.oy !== want.oy) begin
					$display("%0t: owner cell expected (%0d,%0d) got (%0d,%0d)", $time,
						want.ox, want.oy, got.ox, got.oy);
					fail_cnt++;
				end
				if (got.dsq !== want.dsq) begin
					$display("%0t: distance expected %h got %h", $time, want.dsq, got.dsq);
					fail_cnt++;
				end
				if (got.glow !== want.glow) begin
					$display("%0t: glow expected %h got %h", $time, want.glow, got.glow);
					fail_cnt++;
				end
				if (got.hue !== want.hue) begin
					$display("%0t: hue expected %0d got %0d", $time, want.hue, got.hue);
					fail_cnt++;
				end
			end
		end
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			recv_gap <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: count cycles without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic drain_and_write(logic [15:0] ph);
		while (pixel_q.size() > 0 || s_tvalid || owner_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ph;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		phase_model = ph;
	endtask

	// Mostly uniform pixels, some hugging cell borders
	task automatic queue_random_pixels(int n);
		logic [15:0] px;
		logic [15:0] py;
		for (int k = 0; k < n; k++) begin
			px = 16'($urandom);
			py = 16'($urandom);
			if ($urandom_range(0, 4) == 0)
				px = 16'((px & 16'hE000) + $urandom_range(0, 3) - 2);
			if ($urandom_range(0, 4) == 0)
				py = 16'((py & 16'hE000) + $urandom_range(0, 3) - 2);
			pixel_q.push_back({py, px});
		end
	endtask

	initial begin
		longint      root;
		longint      ramp;
		longint      g;
		logic [15:0] edges [10];
		// Build the glow curve with an incremental integer square root
		root = 0;
		for (int i = 0; i < GLOW_DEPTH; i++) begin
			while ((root + 1) * (root + 1) <= (longint'(i) << 16))
				root++;
			ramp = (root * 65536) / GLOW_REACH;
			if (ramp > 32768)
				ramp = 32768;
			g = 65536 - ramp;
			if (g >= 65536)
				g = 65535;
			glow_curve[i] = g[15:0];
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and cell borders, phase zero
		drain_and_write(16'h0000);
		edges = '{16'h0000, 16'hFFFF, 16'h1FFF, 16'h2000, 16'h7FFF,
			16'h8000, 16'hE000, 16'hDFFF, 16'h5555, 16'hAAAA};
		for (int k = 0; k < 10; k++)
			pixel_q.push_back({edges[9 - k], edges[k]});
		for (int k = 0; k < 10; k++)
			pixel_q.push_back({edges[k], edges[k]});
		pixel_q.push_back({16'h0000, 16'hFFFF});
		pixel_q.push_back({16'hFFFF, 16'h0000});
		queue_random_pixels(280);

		drain_and_write(16'hFFFF);
		queue_random_pixels(260);
		drain_and_write(16'h8000);
		queue_random_pixels(260);

		// Fill the pipe against a long receiver hold-off
		drain_and_write(16'h4000);
		queue_random_pixels(260);
		hold_req = 1'b1;

		drain_and_write(16'($urandom));
		queue_random_pixels(260);
		drain_and_write(16'h7FFF);
		queue_random_pixels(260);

		drain_and_write(16'($urandom));
		calm = 1'b1;
		queue_random_pixels(280);

		while (pixel_q.size() > 0 || s_tvalid || owner_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_cnt == 0 && owner_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> voronoi_nearest_feature_pixel.f
design/vnfp_pkg.sv
design/vnfp_cell.sv
design/vnfp_finish.sv
design/voronoi_nearest_feature_pixel.sv
tb/testbench.sv
